// ----- hdl/gb5_pkg.sv -----
// Shared types, constants and weight functions for the 5x5 Gaussian blur.
package gb5_pkg;

    localparam int MAX_WIDTH = 256;
    localparam int MIN_WIDTH = 5;
    localparam int CFG_W     = 9;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROWS_W    = 3;
    localparam int SEEN_W    = 2;
    localparam int CSUM_W    = 12;
    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W    = $clog2(FIFO_DEPTH);
    localparam int FCNT_W    = $clog2(FIFO_DEPTH + 1);

    // red in the lowest bits
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // vertically weighted column sum, one per color
    typedef struct packed {
        logic [CSUM_W-1:0] blue;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] red;
    } colsum_t;

    // four stored rows of one column, index 0 newest
    typedef pix_t [3:0] line_t;

    // results caused by one item: r0 alone, or r0, r1, r2 at row end
    typedef struct packed {
        logic multi;
        pix_t r2;
        pix_t r1;
        pix_t r0;
    } group_t;

    function automatic logic [CSUM_W-1:0] tap5v(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c, input logic [7:0] d,
                                                 input logic [7:0] e);
        logic [CSUM_W-1:0] sum;
        sum = {4'b0, a} + {2'b0, b, 2'b0} + {3'b0, c, 1'b0} + {2'b0, c, 2'b0}
            + {2'b0, d, 2'b0} + {4'b0, e};
        return sum;
    endfunction

    function automatic logic [15:0] tap5h(input logic [CSUM_W-1:0] a,
                                          input logic [CSUM_W-1:0] b,
                                          input logic [CSUM_W-1:0] c,
                                          input logic [CSUM_W-1:0] d,
                                          input logic [CSUM_W-1:0] e);
        logic [15:0] sum;
        sum = {4'b0, a} + {2'b0, b, 2'b0} + {3'b0, c, 1'b0} + {2'b0, c, 2'b0}
            + {2'b0, d, 2'b0} + {4'b0, e};
        return sum;
    endfunction

    function automatic colsum_t vsum_px(input pix_t a, input pix_t b, input pix_t c,
                                        input pix_t d, input pix_t e);
        colsum_t s;
        s.red   = tap5v(a.red,   b.red,   c.red,   d.red,   e.red);
        s.green = tap5v(a.green, b.green, c.green, d.green, e.green);
        s.blue  = tap5v(a.blue,  b.blue,  c.blue,  d.blue,  e.blue);
        return s;
    endfunction

    // weighted horizontal sum, divided by 256 and truncated
    function automatic pix_t blur_px(input colsum_t a, input colsum_t b, input colsum_t c,
                                     input colsum_t d, input colsum_t e);
        pix_t       p;
        logic [15:0] hr;
        logic [15:0] hg;
        logic [15:0] hb;
        hr = tap5h(a.red,   b.red,   c.red,   d.red,   e.red);
        hg = tap5h(a.green, b.green, c.green, d.green, e.green);
        hb = tap5h(a.blue,  b.blue,  c.blue,  d.blue,  e.blue);
        p.red   = hr[15:8];
        p.green = hg[15:8];
        p.blue  = hb[15:8];
        return p;
    endfunction

endpackage

// ----- hdl/gaussian_blur_5x5_rgb_top.sv -----
// 5x5 Gaussian blur of a zero-padded RGB pixel stream, top level.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------
//  s_       | in        | s_tvalid / s_tready    | tdata: red, green, blue; tuser: pad
//  m_       | out       | m_tvalid / m_tready    | tdata: red, green, blue; tlast
//  cfg_     | in        | cfg_wr_en              | cfg_wr_data: image width
//
// One item is accepted per cycle while s_tready is high; a result passes through the line
// store read, the column-sum window and the result queue into the output register. The last
// item of an active row causes three results; a small result queue absorbs them.
// The line store is one 256 x 96-bit memory, read at accept and written back in the next
// cycle; rows not filled since reset are masked by a row count, so reset clears no memory.
// m_tready low holds the output register; s_tready drops when the queue has no room left
// for the items in flight, and it never depends on m_tready in the same cycle.
module gaussian_blur_5x5_rgb_top
    import gb5_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,     // red [7:0], green [15:8], blue [23:16]
    input  logic             s_tuser,     // pad_row
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,     // red [7:0], green [15:8], blue [23:16]
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    logic [CFG_W-1:0]  width_reg;
    logic [COL_W-1:0]  count_reg;
    logic [COL_W-1:0]  count_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [ROWS_W-1:0] filled_reg;
    logic [ROWS_W-1:0] filled_next;

    logic [31:0]       width_eff;
    logic [COL_W-1:0]  last_col;
    logic              in_fire;
    logic              in_last;
    logic [COL_W-1:0]  in_col;
    pix_t              in_pix;
    logic              in_emit;

    line_t             line_mem [MAX_WIDTH];
    line_t             rd_reg;
    line_t             wr_line;

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_multi_reg;
    logic [COL_W-1:0]  s1_col_reg;
    pix_t              s1_pix_reg;
    logic [ROWS_W-1:0] s1_filled_reg;
    logic              s1_clear_reg;

    pix_t              vec [5];
    colsum_t           vs;
    colsum_t           win_reg [5];
    colsum_t           win_next [5];

    logic              s2_push_reg;
    logic              s2_multi_reg;
    group_t            s2_group;

    group_t            grp_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg;
    logic [FPTR_W-1:0] rd_ptr_reg;
    logic [FCNT_W-1:0] fcnt_reg;
    logic [FCNT_W-1:0] fcnt_next;
    logic [FCNT_W:0]   reserve;
    group_t            head;
    logic              out_load;
    logic              out_pop;
    logic              head_last;
    pix_t              head_pix;

    logic              out_valid_reg;
    pix_t              out_data_reg;
    logic              out_last_reg;
    logic [1:0]        k_reg;

    // ---------------- accept side ----------------
    always_comb
    begin
        if (32'(width_reg) < 32'(MIN_WIDTH))
            width_eff = 32'(MIN_WIDTH);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            width_eff = 32'(MAX_WIDTH);
        else
            width_eff = 32'(width_reg);
    end

    assign last_col = COL_W'(width_eff - 32'd1);
    assign in_fire  = s_tvalid && s_tready;
    assign in_last  = (count_reg >= last_col);
    assign in_col   = in_last ? last_col : count_reg;
    assign in_pix   = s_tuser ? '0 : pix_t'(s_tdata);
    assign in_emit  = (s_tuser || (seen_reg >= SEEN_W'(2))) && (in_col >= COL_W'(2));

    // room for this item and every group still in flight
    assign reserve  = {1'b0, fcnt_reg} + (FCNT_W+1)'(s1_valid_reg && s1_emit_reg)
                    + (FCNT_W+1)'(s2_push_reg) + (FCNT_W+1)'(1);
    assign s_tready = (reserve <= (FCNT_W+1)'(FIFO_DEPTH));

    always_comb
    begin
        count_next  = count_reg;
        seen_next   = seen_reg;
        filled_next = filled_reg;
        if (in_fire)
        begin
            if (in_last)
            begin
                count_next = '0;
                if (s_tuser)
                    seen_next = '0;
                else if (seen_reg < SEEN_W'(2))
                    seen_next = seen_reg + SEEN_W'(1);
                if (filled_reg < ROWS_W'(4))
                    filled_next = filled_reg + ROWS_W'(1);
            end
            else
            begin
                count_next = in_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_W'(MAX_WIDTH);
            count_reg    <= '0;
            seen_reg     <= '0;
            filled_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_multi_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                width_reg <= cfg_wr_data;
            count_reg    <= count_next;
            seen_reg     <= seen_next;
            filled_reg   <= filled_next;
            s1_valid_reg <= in_fire;
            s1_emit_reg  <= in_fire && in_emit;
            s1_multi_reg <= in_fire && in_emit && in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg    <= in_col;
            s1_pix_reg    <= in_pix;
            s1_filled_reg <= filled_reg;
            s1_clear_reg  <= (in_col == '0);
        end
    end

    // ---------------- line store ----------------
    assign wr_line = {rd_reg[2], rd_reg[1], rd_reg[0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_reg <= line_mem[in_col];
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= wr_line;
    end

    // ---------------- column sums and window ----------------
    always_comb
    begin
        vec[4] = s1_pix_reg;
        vec[3] = (s1_filled_reg > ROWS_W'(0)) ? rd_reg[0] : '0;
        vec[2] = (s1_filled_reg > ROWS_W'(1)) ? rd_reg[1] : '0;
        vec[1] = (s1_filled_reg > ROWS_W'(2)) ? rd_reg[2] : '0;
        vec[0] = (s1_filled_reg > ROWS_W'(3)) ? rd_reg[3] : '0;
        vs     = vsum_px(vec[0], vec[1], vec[2], vec[3], vec[4]);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            win_next[i] = s1_clear_reg ? '0 : win_reg[i+1];
        win_next[4] = vs;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int i = 0; i < 5; i++)
                win_reg[i] <= win_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_push_reg  <= 1'b0;
            s2_multi_reg <= 1'b0;
        end
        else
        begin
            s2_push_reg  <= s1_valid_reg && s1_emit_reg;
            s2_multi_reg <= s1_multi_reg;
        end
    end

    // row end: the two extra results see zero columns shifted in
    always_comb
    begin
        s2_group.multi = s2_multi_reg;
        s2_group.r0 = blur_px(win_reg[0], win_reg[1], win_reg[2], win_reg[3], win_reg[4]);
        s2_group.r1 = blur_px(win_reg[1], win_reg[2], win_reg[3], win_reg[4], '0);
        s2_group.r2 = blur_px(win_reg[2], win_reg[3], win_reg[4], '0, '0);
    end

    // ---------------- result queue and output register ----------------
    assign head     = grp_mem[rd_ptr_reg];
    assign out_load = (fcnt_reg != '0) && (!out_valid_reg || m_tready);
    assign head_last = !head.multi || (k_reg == 2'd2);
    assign out_pop  = out_load && head_last;

    always_comb
    begin
        unique case (k_reg)
            2'd0:    head_pix = head.r0;
            2'd1:    head_pix = head.r1;
            default: head_pix = head.r2;
        endcase
    end

    always_comb
    begin
        fcnt_next = fcnt_reg;
        if (s2_push_reg && !out_pop)
            fcnt_next = fcnt_reg + FCNT_W'(1);
        else if (!s2_push_reg && out_pop)
            fcnt_next = fcnt_reg - FCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (s2_push_reg)
            grp_mem[wr_ptr_reg] <= s2_group;
        if (out_load)
        begin
            out_data_reg <= head_pix;
            out_last_reg <= head_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            fcnt_reg <= fcnt_next;
            if (s2_push_reg)
                wr_ptr_reg <= wr_ptr_reg + FPTR_W'(1);
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FPTR_W'(1);
                k_reg      <= '0;
            end
            else if (out_load)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- checks ----------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_push_reg && !out_pop) |-> (fcnt_reg < FCNT_W'(FIFO_DEPTH)))
        else $error("group pushed into a full queue");

    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s1_valid_reg) |-> (in_col != s1_col_reg))
        else $error("line store read and write hit the same column");

    a_burst_head: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != 2'd0) |-> ((fcnt_reg != '0) && head.multi))
        else $error("row-end burst lost its queue entry");

    // a width write may leave the column count past the new last column
    a_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (filled_reg <= ROWS_W'(4)) && (seen_reg <= SEEN_W'(2)))
        else $error("row counters out of range");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the 5x5 RGB Gaussian blur stream, with its own blur predictor.
module tb_top
    import gb5_pkg::*;
();

    localparam int LIMIT        = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int RAND_ITEMS   = 480;

    typedef enum {STEP_CFG, STEP_PIX} step_kind_t;
    typedef enum {RUN_IMAGE, RUN_PAD, RUN_MIXED, RUN_NOISE} run_kind_t;

    typedef struct {
        step_kind_t       kind;
        logic [CFG_W-1:0] cfg;
        pix_t             px;
        logic             pad;
        int               n_exp;
    } dir_step_t;

    typedef struct packed {
        pix_t px;
        logic last;
    } blur_res_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;     // red [7:0], green [15:8], blue [23:16]
    logic             s_tuser;     // pad_row
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;     // red [7:0], green [15:8], blue [23:16]
    logic             m_tlast;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    // predictor state
    logic [CFG_W-1:0] width_reg;
    pix_t             line_mem [0:3][0:MAX_WIDTH-1];
    pix_t             win [0:4][0:4];
    pix_t             feed_col [0:4];
    int unsigned      col_cnt;
    int unsigned      rows_seen;
    int unsigned      rows_filled;

    blur_res_t        blurred_q [$];
    dir_step_t        dir_q [$];

    int               errors;
    int               cycles;
    int               rx_hold;
    int               burst_left;
    int               gap;
    int               rand_items;

    gaussian_blur_5x5_rgb_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic int unsigned eff_width();
        if (width_reg < MIN_WIDTH)
            return MIN_WIDTH;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned tap(input int i);
        return (i == 0 || i == 4) ? 1 : ((i == 2) ? 6 : 4);
    endfunction

    task automatic shift_win();
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 4; c++)
                win[r][c] = win[r][c+1];
            win[r][4] = feed_col[r];
        end
    endtask

    function automatic pix_t blur_window();
        int unsigned sr;
        int unsigned sg;
        int unsigned sb;
        int unsigned k;
        pix_t        p;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 5; c++)
            begin
                k = tap(r) * tap(c);
                sr += k * win[r][c].red;
                sg += k * win[r][c].green;
                sb += k * win[r][c].blue;
            end
        end
        p.red   = 8'(sr >> 8);
        p.green = 8'(sg >> 8);
        p.blue  = 8'(sb >> 8);
        return p;
    endfunction

    // Advance the predictor by one accepted item and queue the results it causes.
    task automatic blur_predict(input pix_t px_in, input logic pad, output int n);
        int unsigned w;
        int unsigned c;
        logic        at_end;
        pix_t        px;
        blur_res_t   res [0:2];
        w = eff_width();
        c = col_cnt;
        at_end = (c >= w - 1);
        if (c > w - 1)
            c = w - 1;
        px = pad ? '0 : px_in;
        if (c == 0)
        begin
            for (int r = 0; r < 5; r++)
                for (int j = 0; j < 5; j++)
                    win[r][j] = '0;
        end
        feed_col[4] = px;
        for (int i = 0; i < 4; i++)
            feed_col[3-i] = (i < rows_filled) ? line_mem[i][c] : '0;
        shift_win();
        line_mem[3][c] = line_mem[2][c];
        line_mem[2][c] = line_mem[1][c];
        line_mem[1][c] = line_mem[0][c];
        line_mem[0][c] = px;
        n = 0;
        if ((pad || rows_seen >= 2) && c >= 2)
        begin
            res[0].px = blur_window();
            n = 1;
            if (at_end)
            begin
                // flush the last two centre columns with zero columns
                for (int r = 0; r < 5; r++)
                    feed_col[r] = '0;
                shift_win();
                res[1].px = blur_window();
                shift_win();
                res[2].px = blur_window();
                n = 3;
            end
            for (int k = 0; k < n; k++)
            begin
                res[k].last = (k == n - 1);
                blurred_q.push_back(res[k]);
            end
        end
        if (at_end)
        begin
            col_cnt = 0;
            if (pad)
                rows_seen = 0;
            else if (rows_seen < 2)
                rows_seen++;
            if (rows_filled < 4)
                rows_filled++;
        end
        else
            col_cnt = c + 1;
    endtask

    task automatic push_pixel(input pix_t px, input logic pad, input int n_exp);
        int n;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= pad;
        do
            @(posedge clk);
        while (!s_tready);
        blur_predict(px, pad, n);
        if (n_exp >= 0 && n != n_exp)
            report_mismatch("result count", n, n_exp);
    endtask

    task automatic send_run(input int count, input run_kind_t kind, input bit counted);
        pix_t px;
        logic pad;
        for (int i = 0; i < count; i++)
        begin
            px = 24'($urandom);
            case (kind)
                RUN_IMAGE: pad = 1'b0;
                RUN_PAD:   pad = 1'b1;
                RUN_MIXED: pad = ($urandom_range(0, 7) == 0);
                default:   pad = 1'($urandom_range(0, 1));
            endcase
            push_pixel(px, pad, -1);
            if (counted)
                rand_items++;
        end
    endtask

    // Hold the sender until every queued result is out and the pipe is empty.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        width_reg = v;
    endtask

    task automatic add_step(input step_kind_t kind, input logic [CFG_W-1:0] cfg,
                            input pix_t px, input logic pad, input int n_exp);
        dir_step_t st;
        st.kind  = kind;
        st.cfg   = cfg;
        st.px    = px;
        st.pad   = pad;
        st.n_exp = n_exp;
        dir_q.push_back(st);
    endtask

    // receiver: random stall patterns, plus a long hold when asked
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 2) == 0);
                    default: m_tready <= ((left % 5) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_out
        blur_res_t want;
        pix_t      got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (blurred_q.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, 0);
            else
            begin
                want = blurred_q.pop_front();
                if (got.red !== want.px.red)
                    report_mismatch("red", got.red, want.px.red);
                if (got.green !== want.px.green)
                    report_mismatch("green", got.green, want.px.green);
                if (got.blue !== want.px.blue)
                    report_mismatch("blue", got.blue, want.px.blue);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", m_tlast, want.last);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int               phase;
        int               w;
        int               h;
        int               scen;
        logic [CFG_W-1:0] wv;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        errors      = 0;
        rx_hold     = 0;
        burst_left  = 0;
        gap         = 0;
        rand_items  = 0;
        width_reg   = CFG_W'(MAX_WIDTH);
        col_cnt     = 0;
        rows_seen   = 0;
        rows_filled = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
                line_mem[i][j] = '0;
        for (int r = 0; r < 5; r++)
            for (int j = 0; j < 5; j++)
                win[r][j] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill every line row at full width first, so no narrower setting
        // can later read a column that was never written.
        send_run(2 * MAX_WIDTH, RUN_IMAGE, 0);
        send_run(2 * MAX_WIDTH, RUN_PAD, 0);

        add_step(STEP_CFG, 9'h1FF, 24'h000000, 1'b0, -1);
        add_step(STEP_CFG, 9'h000, 24'h000000, 1'b0, -1);
        // first image row: nothing comes out yet
        add_step(STEP_PIX, '0, 24'h000000, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'h0000FF, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'h00FF00, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'hFF0000, 1'b0, 0);
        // second row with a padding item in the middle
        add_step(STEP_PIX, '0, 24'h123456, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'hFEDCBA, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'hA5A5A5, 1'b1, 1);
        add_step(STEP_PIX, '0, 24'h00FF00, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'h807F01, 1'b0, 0);
        // third row: output active, three results at row end
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b0, 1);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b0, 1);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b0, 3);
        // width 8, then lowered to 5 with the column count already past the end
        add_step(STEP_CFG, 9'd8, 24'h000000, 1'b0, -1);
        add_step(STEP_PIX, '0, 24'h010203, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'hF0E0D0, 1'b0, 0);
        add_step(STEP_PIX, '0, 24'h7F807F, 1'b0, 1);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b0, 1);
        add_step(STEP_PIX, '0, 24'h000000, 1'b0, 1);
        add_step(STEP_PIX, '0, 24'h55AA55, 1'b0, 1);
        add_step(STEP_PIX, '0, 24'hAA55AA, 1'b0, 1);
        add_step(STEP_CFG, 9'd5, 24'h000000, 1'b0, -1);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b1, 3);
        // padding row right after a padding-ended row
        add_step(STEP_PIX, '0, 24'h000000, 1'b1, 0);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b1, 0);
        add_step(STEP_PIX, '0, 24'h000000, 1'b1, 1);
        add_step(STEP_PIX, '0, 24'hFFFFFF, 1'b1, 1);
        add_step(STEP_PIX, '0, 24'h000000, 1'b1, 3);

        foreach (dir_q[i])
        begin
            if (dir_q[i].kind == STEP_CFG)
            begin
                wait_idle();
                write_width(dir_q[i].cfg);
            end
            else
                push_pixel(dir_q[i].px, dir_q[i].pad, dir_q[i].n_exp);
        end

        phase = 0;
        while (rand_items < RAND_ITEMS)
        begin
            wait_idle();
            if (phase == 2)
                wv = ($urandom_range(0, 1) != 0) ? CFG_W'(MAX_WIDTH)
                                                 : CFG_W'($urandom_range(MAX_WIDTH + 1, 511));
            else if ($urandom_range(0, 7) == 0)
                wv = CFG_W'($urandom_range(0, MIN_WIDTH - 1));
            else
                wv = CFG_W'($urandom_range(MIN_WIDTH, 12));
            write_width(wv);
            w = eff_width();
            if (phase == 1)
            begin
                // stall the output long enough to back up the input
                @(posedge clk);
                rx_hold = HOLD_CYCLES;
            end
            scen = (phase <= 2) ? 0 : $urandom_range(0, 9);
            h = (phase == 2) ? 1 : ((phase == 1) ? 5 : $urandom_range(1, 5));
            if (scen <= 6)
            begin
                send_run(h * w, (scen == 6) ? RUN_MIXED : RUN_IMAGE, phase != 2);
                send_run(2 * w, RUN_PAD, phase != 2);
            end
            else if (scen == 7)
                send_run($urandom_range(1, 3) * w, RUN_PAD, 1);
            else if (scen == 8)
                send_run($urandom_range(1, 3 * w), RUN_IMAGE, 1);
            else
                send_run($urandom_range(1, 2 * w), RUN_NOISE, 1);
            phase++;
        end

        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gb5_pkg.sv
hdl/gaussian_blur_5x5_rgb_top.sv
tb/sv/tb_top.sv
